@@ src/gpk_pkg.sv @@
// ----------------------------------------------------------------------------
// gpk_pkg: shared types and constants for the gesture path grid key block
// Point and key transaction types, controller commands, base64 lookup.
// ----------------------------------------------------------------------------
package gpk_pkg;

	localparam int GRID       = 8;
	localparam int MAX_POINTS = 64;

	localparam int COORD_W = 16;
	localparam int CFG_W   = 8;
	localparam int CHAR_W  = 7;
	localparam int AW      = $clog2(MAX_POINTS);
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int CELL_W  = $clog2(GRID);
	localparam int QW      = $clog2(GRID + 1);
	localparam int REM_W   = COORD_W + QW;
	localparam int DC_W    = $clog2(QW);
	localparam int WORD_W  = 2 * COORD_W;

	localparam logic [CFG_W-1:0] FLAT_RESET = 8'd4;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic [CHAR_W-1:0] key_char;
		logic              key_empty;
		logic              key_end;
		logic              path_truncated;
	} key_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_RD,
		S_LOAD,
		S_DIV,
		S_OUT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic check;
		logic load;
		logic div_step;
		logic emit;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic encode;
		logic walk_last;
	} status_t;

	function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] idx);
		logic [CHAR_W-1:0] c;
		if (idx < 6'd26) begin
			c = 7'd65 + CHAR_W'(idx);
		end else if (idx < 6'd52) begin
			c = 7'd97 + CHAR_W'(idx - 6'd26);
		end else if (idx < 6'd62) begin
			c = 7'd48 + CHAR_W'(idx - 6'd52);
		end else if (idx == 6'd62) begin
			c = 7'd43;
		end else begin
			c = 7'd47;
		end
		return c;
	endfunction

endpackage

@@ src/gpk_ram.sv @@
// ----------------------------------------------------------------------------
// gpk_ram: generic single write port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gpk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/gpk_ctrl.sv @@
// ----------------------------------------------------------------------------
// gpk_ctrl: sequencing state machine
// Accepts points, then walks the store one point at a time through the divider.
// ----------------------------------------------------------------------------
module gpk_ctrl
	import gpk_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    last_point,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t            state_q, state_d;
	logic [DC_W-1:0]   step_q;
	logic              div_done;

	assign div_done = (step_q == DC_W'(QW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV && !div_done) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && last_point) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = status.encode ? S_RD : S_IDLE;
			S_RD:    state_d = S_LOAD;
			S_LOAD:  state_d = S_DIV;
			S_DIV: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT:   state_d = status.walk_last ? S_FIN : S_RD;
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			S_CHECK: cmd.check    = 1'b1;
			S_LOAD:  cmd.load     = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_OUT:   cmd.emit     = 1'b1;
			S_FIN:   cmd.fin      = 1'b1;
			default: cmd          = '0;
		endcase
	end

endmodule

@@ src/gpk_dpath.sv @@
// ----------------------------------------------------------------------------
// gpk_dpath: point store, bounding box, cell divider and key output
// Two restoring dividers, one bit per step, quantise x and y in parallel.
// ----------------------------------------------------------------------------
module gpk_dpath
	import gpk_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  point_t           point,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output status_t          status,
	output logic             key_valid,
	output key_t             key
);

	logic [CFG_W-1:0]          flat_q;
	logic [CNT_W-1:0]          count_q;
	logic                      ovf_q;
	logic signed [COORD_W-1:0] left_q, right_q, top_q, bottom_q;
	logic [AW-1:0]             idx_q;
	logic                      use_x_q, use_y_q;
	logic [REM_W-1:0]          remx_q, remy_q, dshx_q, dshy_q;
	logic [QW-1:0]             qx_q, qy_q;
	logic [CELL_W-1:0]         lastx_q, lasty_q;
	logic                      pend_v_q;
	key_t                      pend_q;
	logic                      key_valid_q;
	key_t                      key_q;

	logic                      store_we;
	logic [WORD_W-1:0]         rdata;
	logic signed [COORD_W:0]   dx_w, dy_w, offx_w, offy_w;
	logic [COORD_W-1:0]        dx, dy, offx, offy, fx, fy, fl;
	logic                      fx_lt, fy_lt;
	logic [CELL_W-1:0]         cx, cy;
	logic                      changed;
	key_t                      new_key;

	assign store_we = cmd.accept && (count_q < CNT_W'(MAX_POINTS));

	gpk_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(count_q[AW-1:0]),
		.wdata({point.point_y, point.point_x}),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_comb begin
		dx_w   = {right_q[COORD_W-1], right_q} - {left_q[COORD_W-1], left_q};
		dy_w   = {bottom_q[COORD_W-1], bottom_q} - {top_q[COORD_W-1], top_q};
		dx     = dx_w[COORD_W-1:0];
		dy     = dy_w[COORD_W-1:0];
		fx     = COORD_W'(dx / GRID);
		fy     = COORD_W'(dy / GRID);
		fl     = COORD_W'(flat_q);
		fx_lt  = fx < fl;
		fy_lt  = fy < fl;
		offx_w = {rdata[COORD_W-1], rdata[COORD_W-1:0]} - {left_q[COORD_W-1], left_q};
		offy_w = {rdata[WORD_W-1], rdata[WORD_W-1:COORD_W]} - {top_q[COORD_W-1], top_q};
		offx   = offx_w[COORD_W-1:0];
		offy   = offy_w[COORD_W-1:0];
	end

	assign status.encode    = (fx > fl) || (fy > fl);
	assign status.walk_last = (CNT_W'(idx_q) + 1'b1) == count_q;

	always_comb begin
		cx = '0;
		cy = '0;
		if (use_x_q && dx != '0) begin
			cx = (qx_q >= QW'(GRID)) ? CELL_W'(GRID - 1) : qx_q[CELL_W-1:0];
		end
		if (use_y_q && dy != '0) begin
			cy = (qy_q >= QW'(GRID)) ? CELL_W'(GRID - 1) : qy_q[CELL_W-1:0];
		end
		changed                = !pend_v_q || cx != lastx_q || cy != lasty_q;
		new_key.key_char       = b64_char(6'(6'(cx) + 6'(cy) * 6'(GRID)));
		new_key.key_empty      = 1'b0;
		new_key.key_end        = 1'b0;
		new_key.path_truncated = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_q      <= FLAT_RESET;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
			top_q       <= '0;
			bottom_q    <= '0;
			pend_v_q    <= 1'b0;
			key_valid_q <= 1'b0;
		end else begin
			key_valid_q <= 1'b0;
			if (cfg_we) begin
				flat_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				if (store_we) begin
					count_q <= count_q + 1'b1;
					if (count_q == '0) begin
						left_q   <= point.point_x;
						right_q  <= point.point_x;
						top_q    <= point.point_y;
						bottom_q <= point.point_y;
					end else begin
						if (point.point_x < left_q)   left_q   <= point.point_x;
						if (point.point_x > right_q)  right_q  <= point.point_x;
						if (point.point_y < top_q)    top_q    <= point.point_y;
						if (point.point_y > bottom_q) bottom_q <= point.point_y;
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.check) begin
				pend_v_q <= 1'b0;
				if (!status.encode) begin
					key_valid_q <= 1'b1;
					count_q     <= '0;
					ovf_q       <= 1'b0;
				end
			end
			if (cmd.emit && changed) begin
				key_valid_q <= pend_v_q;
				pend_v_q    <= 1'b1;
			end
			if (cmd.fin) begin
				key_valid_q <= 1'b1;
				count_q     <= '0;
				ovf_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			idx_q   <= '0;
			use_x_q <= fy_lt || !fx_lt;
			use_y_q <= !fy_lt;
			key_q   <= '{key_char: '0, key_empty: 1'b1, key_end: 1'b1, path_truncated: ovf_q};
		end
		if (cmd.load) begin
			remx_q <= REM_W'(offx) * REM_W'(GRID);
			remy_q <= REM_W'(offy) * REM_W'(GRID);
			dshx_q <= REM_W'(dx) << (QW - 1);
			dshy_q <= REM_W'(dy) << (QW - 1);
			qx_q   <= '0;
			qy_q   <= '0;
		end
		if (cmd.div_step) begin
			if (remx_q >= dshx_q) begin
				remx_q <= remx_q - dshx_q;
				qx_q   <= {qx_q[QW-2:0], 1'b1};
			end else begin
				qx_q   <= {qx_q[QW-2:0], 1'b0};
			end
			if (remy_q >= dshy_q) begin
				remy_q <= remy_q - dshy_q;
				qy_q   <= {qy_q[QW-2:0], 1'b1};
			end else begin
				qy_q   <= {qy_q[QW-2:0], 1'b0};
			end
			dshx_q <= dshx_q >> 1;
			dshy_q <= dshy_q >> 1;
		end
		if (cmd.emit) begin
			idx_q <= idx_q + 1'b1;
			if (changed) begin
				key_q   <= pend_q;
				pend_q  <= new_key;
				lastx_q <= cx;
				lasty_q <= cy;
			end
		end
		if (cmd.fin) begin
			key_q <= '{key_char: pend_q.key_char, key_empty: pend_q.key_empty,
				key_end: 1'b1, path_truncated: pend_q.path_truncated};
		end
	end

	assign key_valid = key_valid_q;
	assign key       = key_q;

endmodule

@@ src/gesture_path_grid_key_core.sv @@
// Sequence: a point without the last mark is stored and gives no result.
// After the last point the box is tested, then each stored point passes through
// memory read, operand load, 4 divider steps and a cell compare, and a final step
// releases the last character; an empty key follows the box test directly.
// Throughput: one point per cycle while collecting; busy during the walk.
// Reset (arst_n low): empty store, flat limit 4; results cannot be stalled.
// ----------------------------------------------------------------------------
// gesture_path_grid_key_core: grid key encoder for gesture paths
// Stores a path, then quantises each point into a grid cell and emits base64.
// ----------------------------------------------------------------------------
module gesture_path_grid_key_core
	import gpk_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  point_t           point,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             key_valid,
	output key_t             key
);

	cmd_t    cmd;
	status_t status;

	gpk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_point(point.last_point),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	gpk_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.point    (point),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.status   (status),
		.key_valid(key_valid),
		.key      (key)
	);

`ifndef SYNTHESIS
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && point.last_point |=> busy)
		else $error("last point did not start the walk");

	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key.key_empty |-> key.key_end)
		else $error("empty key not marked as end");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && !key.key_end |-> busy)
		else $error("non-final key character outside the walk");
`endif

endmodule
